// ===== rtl/arp_cache_table_with_aging_unit_assert.svh =====
// Assertion macros shared by the ARP cache RTL.
// All use clk_i as the clock and rst_ni (active low) as the disable.
`ifndef ARP_CACHE_TABLE_WITH_AGING_UNIT_ASSERT_SVH
`define ARP_CACHE_TABLE_WITH_AGING_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ARPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/arpc_pkg.sv =====
package arpc_pkg;

  localparam int CMD_W      = 2;
  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int TIME_W     = 32;
  localparam int TO_W       = 16;
  localparam int SLOT_W     = 5;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;

  localparam logic [TO_W-1:0] TIMEOUT_RST = 16'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  typedef enum logic {
    MODE_MATCH,
    MODE_AGE
  } mode_e;

  typedef struct packed {
    logic [TIME_W-1:0] added;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
  } entry_t;

endpackage

// ===== rtl/arp_cache_table_with_aging_unit.sv =====
// Channel   Dir  Fields (low bit first)
// s_axis    in   tuser: cmd[1:0]; tdata: ip_addr[31:0], mac_addr[79:32]
// m_axis    out  tdata: hit[0], mac_out[48:1], slot[53:49], zero pad [55:54]
// cfg       in   cfg_we_i / cfg_wdata_i: entry_timeout
//
// Lookup, tick and insert all scan the whole table: the scan reads
// the entry RAM one address per cycle and checks each entry in the shared
// compare unit; insert then writes the entry in S_WRITE. Unused commands skip the scan.
// Reset clears all valid bits and the seconds counter and loads the timeout
// with 15; no clearing pass.
// The next transaction is taken once the result sits in the output register;
// a stalled output holds the block in its final state.
`include "arp_cache_table_with_aging_unit_assert.svh"

module arp_cache_table_with_aging_unit #(
  parameter int ENTRIES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arpc_pkg::TO_W-1:0]           cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [arpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // ip_addr, mac_addr
  input  logic [arpc_pkg::CMD_W-1:0]          s_axis_tuser,   // cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [arpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata    // hit, mac_out, slot, pad
);

  import arpc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int XW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e state_q, state_d;

  logic [TO_W-1:0]   timeout_q, timeout_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [IDX_W-1:0]  nowmod_q, nowmod_d;
  logic [ENTRIES-1:0] valid_q, valid_d;

  logic [CMD_W-1:0] cmd_q;
  logic [IP_W-1:0]  key_ip_q;
  logic [MAC_W-1:0] key_mac_q;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] eval_idx_q;
  logic             found_q, found_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [MAC_W-1:0] res_mac_q, res_mac_d;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic accept, issue, ram_we, load_out, out_free, scan_end;
  logic ev_valid, cmp_flag, take, age_out;
  logic [IDX_W-1:0] wr_addr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t rd_entry, wr_entry;
  mode_e  mode;
  logic [XW-1:0] slot_x;

  assign out_free = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign scan_end = pend_q && (eval_idx_q == LAST_IDX);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((s_axis_tuser == CMD_LOOKUP) || (s_axis_tuser == CMD_INSERT) ||
              (s_axis_tuser == CMD_TICK)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = (cmd_q == CMD_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_SCAN:  issue = (rd_idx_q < CNT_W'(ENTRIES));
      S_WRITE: ram_we = 1'b1;
      S_DONE:  load_out = out_free;
      default: ;
    endcase
  end

  assign rd_entry = entry_t'(ram_rdata);
  assign mode     = (cmd_q == CMD_TICK) ? MODE_AGE : MODE_MATCH;
  assign ev_valid = valid_q[eval_idx_q];

  arpc_match u_match (
    .mode_i        (mode),
    .key_ip_i      (key_ip_q),
    .entry_ip_i    (rd_entry.ip),
    .entry_added_i (rd_entry.added),
    .now_i         (now_q),
    .timeout_i     (timeout_q),
    .flag_o        (cmp_flag)
  );

  always_comb begin
    take    = 1'b0;
    age_out = 1'b0;
    if (pend_q && (state_q == S_SCAN) && !found_q) begin
      if (cmd_q == CMD_LOOKUP) begin
        take = ev_valid && cmp_flag;
      end else if (cmd_q == CMD_INSERT) begin
        take = !ev_valid;
      end
    end
    if (pend_q && (state_q == S_SCAN) && (cmd_q == CMD_TICK)) begin
      age_out = ev_valid && cmp_flag;
    end
  end

  assign wr_addr        = found_q ? slot_q : nowmod_q;
  assign wr_entry.added = now_q;
  assign wr_entry.mac   = key_mac_q;
  assign wr_entry.ip    = key_ip_q;

  arpc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (issue),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    timeout_d = cfg_we_i ? cfg_wdata_i : timeout_q;
    now_d     = now_q;
    nowmod_d  = nowmod_q;
    valid_d   = valid_q;
    rd_idx_d  = rd_idx_q;
    pend_d    = issue;
    found_d   = found_q;
    slot_d    = slot_q;
    res_mac_d = res_mac_q;

    if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
    if (accept) begin
      rd_idx_d  = '0;
      found_d   = 1'b0;
      slot_d    = '0;
      res_mac_d = '0;
      if (s_axis_tuser == CMD_TICK) begin
        now_d = now_q + TIME_W'(1);
        if (now_d == '0) begin
          nowmod_d = '0;
        end else if (nowmod_q == LAST_IDX) begin
          nowmod_d = '0;
        end else begin
          nowmod_d = nowmod_q + IDX_W'(1);
        end
      end
    end
    if (take) begin
      found_d = 1'b1;
      slot_d  = eval_idx_q;
      if (cmd_q == CMD_LOOKUP) begin
        res_mac_d = rd_entry.mac;
      end
    end
    if (age_out) begin
      valid_d[eval_idx_q] = 1'b0;
    end
    if (ram_we) begin
      valid_d[wr_addr] = 1'b1;
      slot_d           = wr_addr;
    end

    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      timeout_q <= TIMEOUT_RST;
      now_q     <= '0;
      nowmod_q  <= '0;
      valid_q   <= '0;
      rd_idx_q  <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      timeout_q <= timeout_d;
      now_q     <= now_d;
      nowmod_q  <= nowmod_d;
      valid_q   <= valid_d;
      rd_idx_q  <= rd_idx_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign slot_x = XW'(slot_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= s_axis_tuser;
      key_ip_q  <= s_axis_tdata[IP_W-1:0];
      key_mac_q <= s_axis_tdata[IP_W +: MAC_W];
    end
    eval_idx_q <= rd_idx_q[IDX_W-1:0];
    slot_q     <= slot_d;
    res_mac_q  <= res_mac_d;
    if (load_out) begin
      m_data_q <= {2'b00, slot_x[SLOT_W-1:0], res_mac_q,
                   found_q && (cmd_q == CMD_LOOKUP)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ARPC_ASSERT_IMP(a_hit_valid, found_q && (cmd_q == CMD_LOOKUP), valid_q[slot_q], "lookup hit on invalid slot")
  `ARPC_ASSERT_IMP(a_write_insert, state_q == S_WRITE, cmd_q == CMD_INSERT, "table write outside insert")
  `ARPC_ASSERT_IMP(a_no_evict_free, (state_q == S_WRITE) && valid_q[wr_addr], &valid_q, "valid slot overwritten with free slots left")
  `ARPC_ASSERT_NXT(a_tick_adv, accept && (s_axis_tuser == CMD_TICK), now_q == TIME_W'($past(now_q) + TIME_W'(1)), "seconds counter did not advance")
  `ARPC_ASSERT(a_nowmod_range, nowmod_q <= LAST_IDX, "seconds modulo out of range")

endmodule

// ===== rtl/arpc_ram.sv =====
module arpc_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/arpc_match.sv =====
module arpc_match (
  input  arpc_pkg::mode_e                mode_i,
  input  logic [arpc_pkg::IP_W-1:0]      key_ip_i,
  input  logic [arpc_pkg::IP_W-1:0]      entry_ip_i,
  input  logic [arpc_pkg::TIME_W-1:0]    entry_added_i,
  input  logic [arpc_pkg::TIME_W-1:0]    now_i,
  input  logic [arpc_pkg::TO_W-1:0]      timeout_i,
  output logic                           flag_o
);

  import arpc_pkg::*;

  // one subtractor: ip equality in match mode, entry age in age mode
  logic [TIME_W-1:0] op_a;
  logic [TIME_W-1:0] op_b;
  logic [TIME_W-1:0] diff;

  always_comb begin
    if (mode_i == MODE_AGE) begin
      op_a = now_i;
      op_b = entry_added_i;
    end else begin
      op_a = entry_ip_i;
      op_b = key_ip_i;
    end
    diff = op_a - op_b;
    if (mode_i == MODE_AGE) begin
      flag_o = diff > TIME_W'(timeout_i);
    end else begin
      flag_o = (diff == '0);
    end
  end

endmodule
